// ----- design/sba_pkg.sv -----
package sba_pkg;

  localparam int unsigned InTdataW  = 56;
  localparam int unsigned OutTdataW = 72;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_TOO_BIG = 2'd1;
  localparam logic [1:0] STATUS_NO_SLOT = 2'd2;

  localparam logic [1:0] CFG_OBJ_SIZE   = 2'd0;
  localparam logic [1:0] CFG_INIT_LOG2  = 2'd1;
  localparam logic [1:0] CFG_FIRST_FREE = 2'd2;

  localparam logic [4:0] MIN_SEG_LOG2 = 5'd16;

  typedef struct packed {
    logic [23:0] ids_in_use;
    logic [30:0] size_bytes;
  } req_item_t;

  typedef struct packed {
    logic [34:0] file_extent;
    logic        new_segment;
    logic [25:0] offset_units;
    logic [3:0]  segment;
    logic [1:0]  status;
  } res_item_t;

  typedef struct packed {
    logic        we;
    logic [1:0]  idx;
    logic [15:0] data;
  } cfg_wr_t;

endpackage

// ----- design/segmented_bump_allocator.sv -----
// Requests pass the input register, then the output register as result beats.
// Throughput: one request per cycle unless the output stalls.
// A full output register does not stop intake while the input register is free.
// Reset clears the allocator to segment 0, base 0, segment size 2^16, offset 0,
// and the registers to obj_size 0, init_seg_log2 16, first_free_offset 0.
module segmented_bump_allocator
  import sba_pkg::*;
#(
  parameter int unsigned MAX_SEG_LOG2 = 30,
  parameter int unsigned SEG_SLOTS    = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // size_bytes[30:0], ids_in_use[54:31], zero pad[55]
  input  logic [InTdataW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // status[1:0], segment[5:2], offset_units[31:6], new_segment[32],
  // file_extent[67:33], zero pad[71:68]
  output logic [OutTdataW-1:0] m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i
);

  logic      in_valid;
  logic      out_ready;
  logic [$bits(req_item_t)-1:0] in_data;
  logic [$bits(res_item_t)-1:0] out_data;
  req_item_t req;
  res_item_t res;
  cfg_wr_t   cfg;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  sba_stage #(
    .WIDTH ($bits(req_item_t))
  ) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (s_axis_tdata[$bits(req_item_t)-1:0]),
    .valid_o (in_valid),
    .ready_i (out_ready),
    .data_o  (in_data)
  );

  assign req = req_item_t'(in_data);

  sba_core #(
    .MAX_SEG_LOG2 (MAX_SEG_LOG2),
    .SEG_SLOTS    (SEG_SLOTS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (in_valid && out_ready),
    .req_i  (req),
    .res_o  (res)
  );

  sba_stage #(
    .WIDTH ($bits(res_item_t))
  ) u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .ready_o (out_ready),
    .data_i  (res),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_data)
  );

  assign m_axis_tdata = {(OutTdataW - $bits(res_item_t))'(0), out_data};

endmodule

// ----- design/sba_stage.sv -----
module sba_stage
  import sba_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o
);

  logic             valid_q;
  logic [WIDTH-1:0] data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

// ----- design/sba_core.sv -----
module sba_core
  import sba_pkg::*;
#(
  parameter int unsigned MAX_SEG_LOG2 = 30,
  parameter int unsigned SEG_SLOTS    = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_wr_t   cfg_i,
  input  logic      fire_i,
  input  req_item_t req_i,
  output res_item_t res_o
);

  localparam int unsigned SL_W = $clog2(MAX_SEG_LOG2 + 1);
  localparam int unsigned SB_W = MAX_SEG_LOG2 + 1;
  localparam int unsigned CS_W = $clog2(SEG_SLOTS);
  localparam logic [32:0] MAX_BYTES = 33'(1) << MAX_SEG_LOG2;
  localparam logic [SL_W-1:0] MAX_L = SL_W'(MAX_SEG_LOG2);

  logic [15:0]     obj_size_q;
  logic [4:0]      init_log2_q;
  logic [11:0]     first_free_q;
  logic [CS_W-1:0] cur_seg_q, cur_seg_d;
  logic [SL_W-1:0] seg_log2_q, seg_log2_d;
  logic [34:0]     seg_base_q, seg_base_d;
  logic [26:0]     next_units_q, next_units_d;

  logic [31:0]     req;
  logic [SB_W-1:0] seg_bytes;
  logic [39:0]     reserved;
  logic [SB_W-1:0] room;
  logic [33:0]     need;
  logic            overflow;
  logic            too_big;
  logic            no_slot;
  logic            opened;
  logic [1:0]      status;
  logic [CS_W:0]   cur_p1;
  logic [SL_W:0]   base_l;
  logic [SL_W-1:0] new_l;
  logic [26:0]     grant;

  function automatic logic [SL_W-1:0] clamp_log2(input logic [4:0] v);
    logic [SL_W-1:0] r;
    if (v < MIN_SEG_LOG2) begin
      r = SL_W'(MIN_SEG_LOG2);
    end else if ({1'b0, v} > 6'(MAX_SEG_LOG2)) begin
      r = MAX_L;
    end else begin
      r = SL_W'(v);
    end
    return r;
  endfunction

  assign req       = ({1'b0, req_i.size_bytes} + 32'd63) & ~32'd63;
  assign seg_bytes = SB_W'(1) << seg_log2_q;
  assign reserved  = 40'(req_i.ids_in_use) * 40'(obj_size_q);
  assign room      = (reserved > 40'(seg_bytes)) ? '0 : seg_bytes - SB_W'(reserved);
  assign need      = 34'({next_units_q, 4'b0000}) + 34'(req);
  assign overflow  = need > 34'(room);
  assign too_big   = 33'(req) > MAX_BYTES;
  assign cur_p1    = {1'b0, cur_seg_q} + (CS_W + 1)'(1);
  assign no_slot   = cur_p1 >= (CS_W + 1)'(SEG_SLOTS);
  assign base_l    = {1'b0, seg_log2_q} + (SL_W + 1)'(1);

  always_comb begin
    new_l = MAX_L;
    for (int k = MAX_SEG_LOG2; k >= 0; k--) begin
      if ((33'(req) <= (33'(1) << k)) && ((SL_W + 1)'(k) >= base_l)) begin
        new_l = SL_W'(k);
      end
    end
  end

  always_comb begin
    status = STATUS_OK;
    opened = 1'b0;
    priority if (overflow && too_big) begin
      status = STATUS_TOO_BIG;
    end else if (overflow && no_slot) begin
      status = STATUS_NO_SLOT;
    end else if (overflow) begin
      opened = 1'b1;
    end
  end

  always_comb begin
    cur_seg_d  = cur_seg_q;
    seg_log2_d = seg_log2_q;
    seg_base_d = seg_base_q;
    grant      = next_units_q;
    if (opened) begin
      cur_seg_d  = cur_p1[CS_W-1:0];
      seg_log2_d = new_l;
      seg_base_d = seg_base_q + 35'(seg_bytes);
      grant      = '0;
    end
    next_units_d = 27'(28'(grant) + 28'(req[31:4]));
  end

  always_comb begin
    res_o.status       = status;
    res_o.segment      = 4'(cur_seg_d);
    res_o.offset_units = (status == STATUS_OK) ? grant[25:0] : '0;
    res_o.new_segment  = opened;
    res_o.file_extent  = seg_base_d + (35'(1) << seg_log2_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_size_q   <= '0;
      init_log2_q  <= MIN_SEG_LOG2;
      first_free_q <= '0;
      cur_seg_q    <= '0;
      seg_log2_q   <= SL_W'(MIN_SEG_LOG2);
      seg_base_q   <= '0;
      next_units_q <= '0;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        CFG_OBJ_SIZE: begin
          obj_size_q <= cfg_i.data;
        end
        CFG_INIT_LOG2: begin
          init_log2_q  <= cfg_i.data[4:0];
          cur_seg_q    <= '0;
          seg_base_q   <= '0;
          seg_log2_q   <= clamp_log2(cfg_i.data[4:0]);
          next_units_q <= 27'(first_free_q);
        end
        CFG_FIRST_FREE: begin
          first_free_q <= cfg_i.data[11:0];
          cur_seg_q    <= '0;
          seg_base_q   <= '0;
          seg_log2_q   <= clamp_log2(init_log2_q);
          next_units_q <= 27'(cfg_i.data[11:0]);
        end
        default: begin
        end
      endcase
    end else if (fire_i && (status == STATUS_OK)) begin
      cur_seg_q    <= cur_seg_d;
      seg_log2_q   <= seg_log2_d;
      seg_base_q   <= seg_base_d;
      next_units_q <= next_units_d;
    end
  end

endmodule

// ----- tb/tb_segmented_bump_allocator.sv -----
module tb_segmented_bump_allocator;
  import sba_pkg::*;

  localparam int unsigned SegMaxLog2 = 30;
  localparam int unsigned SegSlots   = 16;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // size_bytes[30:0], ids_in_use[54:31], zero pad[55]
  logic [InTdataW-1:0]  s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // status[1:0], segment[5:2], offset_units[31:6], new_segment[32],
  // file_extent[67:33], zero pad[71:68]
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 cfg_we_i;
  logic [1:0]           cfg_idx_i;
  logic [15:0]          cfg_data_i;

  segmented_bump_allocator #(
    .MAX_SEG_LOG2(SegMaxLog2),
    .SEG_SLOTS   (SegSlots)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // allocator shadow state and registers
  logic [15:0] reg_obj_size;
  logic [4:0]  reg_init_log2;
  logic [11:0] reg_first_free;
  int unsigned alloc_seg;
  int          alloc_log2;
  logic [34:0] alloc_base;
  logic [26:0] alloc_next;

  res_item_t grants_due[$];
  int        errors = 0;
  int        stall_left = 0;
  logic      steady = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic void restart_alloc();
    int l;
    l = reg_init_log2;
    if (l < MIN_SEG_LOG2) l = MIN_SEG_LOG2;
    if (l > SegMaxLog2) l = SegMaxLog2;
    alloc_seg  = 0;
    alloc_base = '0;
    alloc_log2 = l;
    alloc_next = 27'(reg_first_free);
  endfunction

  function automatic res_item_t predict_grant(req_item_t it);
    logic [63:0] req, seg_bytes, reserved, room;
    int          l;
    res_item_t   r;
    req       = ({33'd0, it.size_bytes} + 64'd63) & ~64'd63;
    seg_bytes = 64'd1 << alloc_log2;
    reserved  = 64'(it.ids_in_use) * 64'(reg_obj_size);
    room      = (reserved > seg_bytes) ? 64'd0 : seg_bytes - reserved;
    r         = '0;
    r.status  = STATUS_OK;
    if (64'(alloc_next) * 64'd16 + req > room) begin
      if (req > (64'd1 << SegMaxLog2)) begin
        r.status = STATUS_TOO_BIG;
      end else if (alloc_seg + 1 >= SegSlots) begin
        r.status = STATUS_NO_SLOT;
      end else begin
        l = alloc_log2 + 1;
        while (l < SegMaxLog2 && (64'd1 << l) < req) l++;
        if (l > SegMaxLog2) l = SegMaxLog2;
        alloc_base    = alloc_base + seg_bytes[34:0];
        alloc_log2    = l;
        alloc_seg     = alloc_seg + 1;
        alloc_next    = '0;
        r.new_segment = 1'b1;
      end
    end
    r.segment = alloc_seg[3:0];
    if (r.status == STATUS_OK) begin
      r.offset_units = alloc_next[25:0];
      alloc_next     = alloc_next + 27'(req >> 4);
    end
    r.file_extent = alloc_base + (35'd1 << alloc_log2);
    return r;
  endfunction

  // shadow register writes and accepted requests in beat order
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_obj_size   = '0;
      reg_init_log2  = MIN_SEG_LOG2;
      reg_first_free = '0;
      restart_alloc();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OBJ_SIZE: begin
            reg_obj_size = cfg_data_i;
          end
          CFG_INIT_LOG2: begin
            reg_init_log2 = cfg_data_i[4:0];
            restart_alloc();
          end
          CFG_FIRST_FREE: begin
            reg_first_free = cfg_data_i[11:0];
            restart_alloc();
          end
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        grants_due.push_back(predict_grant(req_item_t'(s_axis_tdata[54:0])));
      end
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    res_item_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (grants_due.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat: expected none actual %0h", $time, m_axis_tdata);
      end else begin
        want = grants_due.pop_front();
        got  = res_item_t'(m_axis_tdata[67:0]);
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("segment", 64'(want.segment), 64'(got.segment));
        check_field("offset_units", 64'(want.offset_units), 64'(got.offset_units));
        check_field("new_segment", 64'(want.new_segment), 64'(got.new_segment));
        check_field("file_extent", 64'(want.file_extent), 64'(got.file_extent));
        check_field("pad", 64'd0, 64'(m_axis_tdata[71:68]));
      end
    end
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // hold ready low for random stretches
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 2) == 0) begin
      stall_left    <= rand_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_req(input logic [30:0] size, input logic [23:0] ids);
    int        gap;
    req_item_t it;
    gap           = steady ? 0 : rand_gap();
    it.size_bytes = size;
    it.ids_in_use = ids;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, it};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // drop valid and drain every outstanding grant
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (grants_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [30:0] rand_size();
    int unsigned r, span;
    r    = $urandom_range(0, 99);
    span = 32'd1 << alloc_log2;
    if (r < 5) return '0;
    if (r < 55) return 31'($urandom_range(1, span >> 3));
    if (r < 75) return 31'($urandom_range(1, 4096));
    if (r < 85) return 31'($urandom_range(span >> 1, span));
    if (r < 95) return 31'((32'd1 << $urandom_range(16, 30)) + $urandom_range(0, 126) - 63);
    return 31'($urandom_range(0, 32'h7FFF_FFFF));
  endfunction

  function automatic logic [23:0] rand_ids();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 24'($urandom_range(0, 15));
    if (r < 9) return 24'($urandom_range(0, 4095));
    return 24'($urandom_range(0, 24'hFF_FFFF));
  endfunction

  function automatic logic [15:0] rand_obj_size();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'($urandom_range(1, 64));
      2: return 16'($urandom_range(0, 16'hFFFF));
      default: return 16'hFFFF;
    endcase
  endfunction

  task automatic test_small_grants();
    send_req(31'd0, 24'd0);
    send_req(31'd1, 24'd0);
    send_req(31'd64, 24'd0);
    send_req(31'd65, 24'd0);
    send_req(31'd0, 24'd0);
  endtask

  task automatic test_oversize();
    send_req(31'h7FFF_FFFF, 24'd0);
    send_req(31'h4000_0001, 24'd0);
    send_req(31'h4000_0000, 24'd0);
  endtask

  // ids above the segment leave no room, so every non-empty request opens a segment
  task automatic test_slot_exhaustion();
    wait_idle();
    write_reg(CFG_OBJ_SIZE, 16'hFFFF);
    write_reg(CFG_INIT_LOG2, 16'd31);
    write_reg(CFG_FIRST_FREE, 16'd4095);
    send_req(31'd0, 24'hFF_FFFF);
    send_req(31'd0, 24'hFF_FFFF);
    repeat (SegSlots - 1) send_req(31'd64, 24'hFF_FFFF);
    send_req(31'h7FFF_FFFF, 24'hFF_FFFF);
  endtask

  task automatic test_random_phases();
    logic [4:0] init_pick[4];
    logic [4:0] init_val;
    logic [11:0] free_val;
    init_pick = '{5'd0, 5'd15, 5'd30, 5'd31};
    for (int p = 0; p < 12; p++) begin
      wait_idle();
      steady = (p % 4 == 3);
      if (p < 4) init_val = init_pick[p];
      else if ($urandom_range(0, 4) == 0) init_val = 5'($urandom_range(0, 31));
      else init_val = 5'($urandom_range(16, 30));
      if (p == 0) free_val = 12'hFFF;
      else if (p == 1) free_val = 12'd0;
      else free_val = 12'($urandom_range(0, 4095));
      write_reg(CFG_OBJ_SIZE, rand_obj_size());
      write_reg(CFG_INIT_LOG2, 16'(init_val));
      write_reg(CFG_FIRST_FREE, 16'(free_val));
      for (int i = 0; i < 102; i++) begin
        // change the id slot size mid-run; the allocator keeps its place
        if (i == 51) begin
          wait_idle();
          write_reg(CFG_OBJ_SIZE, rand_obj_size());
        end
        send_req(rand_size(), rand_ids());
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_OBJ_SIZE;
    cfg_data_i    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_small_grants();
    test_oversize();
    test_slot_exhaustion();
    test_random_phases();
    wait_idle();
    repeat (6) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
